FILE: src/qea_pkg.sv
// Shared types, constants and tables for the quadrature encoder accelerator.
// Used by the position and configuration channel interfaces, the decoder, the motion unit and the top level.
package qea_pkg;

    localparam int PosW    = 16;
    localparam int MaxVelW = 15;
    localparam int IdxW    = 3;
    localparam int QsW     = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 16;
    localparam int IncW    = 9;

    localparam logic [7:0] STATE_MASK  = 8'h0F;
    localparam logic [7:0] DIR_MASK    = 8'h30;
    localparam logic [7:0] DIR_CW_BIT  = 8'h10;
    localparam logic [7:0] DIR_CCW_BIT = 8'h20;

    localparam logic signed [PosW-1:0] FIXED_VELOCITY = 16'sd1500;
    localparam logic [IdxW-1:0]        ACCEL_LAST     = 3'd4;

    // Reset values of the configuration registers
    localparam logic                   RST_ACCEL_EN = 1'b1;
    localparam logic signed [PosW-1:0] RST_MIN_POS  = 16'sd0;
    localparam logic signed [PosW-1:0] RST_MAX_POS  = 16'sd16383;
    localparam logic [MaxVelW-1:0]     RST_MAX_VEL  = 15'd1500;

    // Half-step decoder: next state in the low bits, direction flag in bits 5:4
    localparam logic [7:0] STEP_TABLE [6][4] = '{
        '{8'h03, 8'h02, 8'h01, 8'h00},
        '{8'h23, 8'h00, 8'h01, 8'h00},
        '{8'h13, 8'h02, 8'h00, 8'h00},
        '{8'h03, 8'h05, 8'h04, 8'h00},
        '{8'h03, 8'h03, 8'h04, 8'h10},
        '{8'h03, 8'h05, 8'h03, 8'h20}
    };

    // Velocity increment per acceleration index
    localparam logic [IncW-1:0] ACCEL_STEP [5] = '{
        9'd0, 9'd16, 9'd60, 9'd180, 9'd400
    };

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ACCEL_EN = 2'd0,
        CFG_MIN_POS  = 2'd1,
        CFG_MAX_POS  = 2'd2,
        CFG_MAX_VEL  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    typedef struct packed {
        logic cw;
        logic ccw;
    } t_step;

    typedef struct packed {
        logic                   accel_en;
        logic signed [PosW-1:0] min_pos;
        logic signed [PosW-1:0] max_pos;
        logic [MaxVelW-1:0]     max_vel;
    } t_cfg;

endpackage

FILE: src/qea_pins_if.sv
// Input channel: one sample of the encoder pins per word.
// Depends on nothing else.
interface qea_pins_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;

    modport source (output valid, output pin_a, output pin_b, input ready);
    modport sink   (input valid, input pin_a, input pin_b, output ready);
endinterface

FILE: src/qea_pos_if.sv
// Output channel: one clamped position per word.
// Depends on qea_pkg for the position width.
interface qea_pos_if
    import qea_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic signed [PosW-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

FILE: src/qea_cfg_if.sv
// Configuration write channel: register index and write data per word.
// Depends on qea_pkg for the index and data widths.
interface qea_cfg_if
    import qea_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/qea_decode.sv
// Half-step quadrature state table: holds the decoder state, reports detent steps.
// Depends on qea_pkg for the step table and the step struct.
module qea_decode
    import qea_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    input  logic  i_pin_a,
    input  logic  i_pin_b,
    output t_step o_step
);

    logic [QsW-1:0] r_qs;
    logic [QsW-1:0] n_qs;
    logic [QsW-1:0] row;
    logic [1:0]     col;
    logic [7:0]     entry;

    always_comb begin
        col   = {i_pin_b, i_pin_a};
        // unreachable codes fall back to the start state
        row   = (r_qs > 3'd5) ? '0 : r_qs;
        entry = STEP_TABLE[row][col];
        n_qs  = entry[QsW-1:0] & STATE_MASK[QsW-1:0];
        o_step.cw  = (entry & DIR_MASK) == DIR_CW_BIT;
        o_step.ccw = (entry & DIR_MASK) == DIR_CCW_BIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qs <= '0;
        end else if (i_advance) begin
            r_qs <= n_qs;
        end
    end

`ifndef SYNTH
    a_qs_reachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qs <= 3'd5)
        else $error("decoder state left the table");

    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_step.cw && o_step.ccw))
        else $error("both directions flagged at once");

    a_qs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_qs))
        else $error("decoder state moved without a sample");
`endif

endmodule

FILE: src/qea_motion.sv
// Velocity, acceleration index and position update for one decoded sample.
// Depends on qea_pkg for the acceleration table, config and step structs.
module qea_motion
    import qea_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  t_step                  i_step,
    input  t_cfg                   i_cfg,
    output logic signed [PosW-1:0] o_new_pos,
    output logic                   o_changed
);

    t_dir                   r_last_dir;
    logic [IdxW-1:0]        r_idx;
    logic signed [PosW-1:0] r_vel;
    logic signed [PosW-1:0] r_pos;

    t_dir                   n_last_dir;
    logic [IdxW-1:0]        n_idx;
    logic signed [PosW-1:0] n_vel;
    logic signed [PosW-1:0] n_pos;

    logic                   any_step;
    t_dir                   dcode;
    logic                   same_dir;
    logic signed [PosW-1:0] base_vel;
    logic signed [PosW:0]   inc;
    logic signed [PosW:0]   vel_sum;
    logic signed [PosW-1:0] limit;
    logic signed [PosW-1:0] step_amt;
    logic signed [PosW:0]   pos_sum;
    logic signed [PosW:0]   min_ext;
    logic signed [PosW:0]   max_ext;

    always_comb begin
        any_step   = i_step.cw || i_step.ccw;
        dcode      = i_step.cw ? DIR_CW : (i_step.ccw ? DIR_CCW : DIR_NONE);
        same_dir   = (r_last_dir == dcode);
        n_last_dir = r_last_dir;
        n_idx      = r_idx;
        n_vel      = r_vel;

        // acceleration: same direction advances the index and wraps it after the last, a reversal restarts
        if (same_dir) begin
            n_idx    = (r_idx >= ACCEL_LAST) ? '0 : r_idx + 3'd1;
            base_vel = r_vel;
        end else begin
            n_idx    = '0;
            base_vel = '0;
        end
        inc     = signed'({{(PosW+1-IncW){1'b0}}, ACCEL_STEP[n_idx]});
        vel_sum = i_step.ccw ? ({base_vel[PosW-1], base_vel} - inc)
                             : ({base_vel[PosW-1], base_vel} + inc);

        if (!i_cfg.accel_en) begin
            n_idx = r_idx;
            if (any_step) begin
                n_vel = i_step.cw ? FIXED_VELOCITY : -FIXED_VELOCITY;
            end
        end else if (!any_step) begin
            // decay toward zero and hold there
            n_idx = r_idx;
            if (r_vel > 16'sd0) begin
                n_vel = r_vel - 16'sd1;
            end else if (r_vel < 16'sd0) begin
                n_vel = r_vel + 16'sd1;
            end
        end else begin
            n_last_dir = dcode;
            if (vel_sum > 17'sd32767) begin
                n_vel = 16'sh7FFF;
            end else if (vel_sum < -17'sd32768) begin
                n_vel = 16'sh8000;
            end else begin
                n_vel = vel_sum[PosW-1:0];
            end
        end

        limit = signed'({1'b0, i_cfg.max_vel});
        if (n_vel < -limit) begin
            step_amt = -limit;
        end else if (n_vel > limit) begin
            step_amt = limit;
        end else begin
            step_amt = n_vel;
        end

        pos_sum = {r_pos[PosW-1], r_pos} + {step_amt[PosW-1], step_amt};
        min_ext = {i_cfg.min_pos[PosW-1], i_cfg.min_pos};
        max_ext = {i_cfg.max_pos[PosW-1], i_cfg.max_pos};
        if (pos_sum < min_ext) begin
            n_pos = i_cfg.min_pos;
        end else if (pos_sum > max_ext) begin
            n_pos = i_cfg.max_pos;
        end else begin
            n_pos = pos_sum[PosW-1:0];
        end
        if (!any_step) begin
            n_pos = r_pos;
        end

        o_new_pos = n_pos;
        o_changed = any_step && (n_pos != r_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dir <= DIR_NONE;
            r_idx      <= '0;
            r_vel      <= '0;
            r_pos      <= '0;
        end else if (i_advance) begin
            r_last_dir <= n_last_dir;
            r_idx      <= n_idx;
            r_vel      <= n_vel;
            r_pos      <= n_pos;
        end
    end

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= ACCEL_LAST)
        else $error("acceleration index out of range");

    a_idle_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_step.cw && !i_step.ccw) |=> $stable(r_pos))
        else $error("position moved on an idle sample");

    a_fixed_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_cfg.accel_en && i_step.cw) |=> (r_vel == FIXED_VELOCITY))
        else $error("fixed mode velocity wrong");
`endif

endmodule

FILE: src/quadrature_encoder_accel_unit.sv
// Top level of the quadrature encoder accelerator: channels, config registers,
// input and result registers. Depends on qea_pkg, the channel interfaces,
// qea_decode and qea_motion.

// Takes one pin sample per clock unless stalled. Each accepted sample is held in
// the input register, and when the position changed its new position is
// registered in the result register; samples that move nothing give no word.
// The decoder, velocity and position update are combinational, and each sample's
// state feeds into the next. A result word that is not taken holds the sample
// behind it in the input register, which stalls the input until the word is taken.
// Configuration writes are always accepted and take effect on the next sample;
// write them only while no sample is in flight.
module quadrature_encoder_accel_unit
    import qea_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    qea_pins_if.sink   i_pins,
    qea_cfg_if.sink    i_cfg,
    qea_pos_if.source  o_pos
);

    logic                   r_in_valid;
    logic                   r_pin_a;
    logic                   r_pin_b;
    logic                   r_out_valid;
    logic signed [PosW-1:0] r_out_pos;
    t_cfg                   r_cfg;

    logic                   advance;
    t_step                  step;
    logic signed [PosW-1:0] new_pos;
    logic                   changed;

    // advance the held sample when the result slot is free or being emptied
    assign advance      = r_in_valid && (!r_out_valid || o_pos.ready);
    assign i_pins.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;
    assign o_pos.valid    = r_out_valid;
    assign o_pos.position = r_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_en <= RST_ACCEL_EN;
            r_cfg.min_pos  <= RST_MIN_POS;
            r_cfg.max_pos  <= RST_MAX_POS;
            r_cfg.max_vel  <= RST_MAX_VEL;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ACCEL_EN: r_cfg.accel_en <= i_cfg.data[0];
                CFG_MIN_POS:  r_cfg.min_pos  <= signed'(i_cfg.data[PosW-1:0]);
                CFG_MAX_POS:  r_cfg.max_pos  <= signed'(i_cfg.data[PosW-1:0]);
                CFG_MAX_VEL:  r_cfg.max_vel  <= i_cfg.data[MaxVelW-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pins.ready) begin
            r_in_valid <= i_pins.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_a <= 1'b0;
            r_pin_b <= 1'b0;
        end else if (i_pins.valid && i_pins.ready) begin
            r_pin_a <= i_pins.pin_a;
            r_pin_b <= i_pins.pin_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && changed) begin
            r_out_valid <= 1'b1;
        end else if (o_pos.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && changed) begin
            r_out_pos <= new_pos;
        end
    end

    qea_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_pin_a   (r_pin_a),
        .i_pin_b   (r_pin_b),
        .o_step    (step)
    );

    qea_motion u_motion (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_step    (step),
        .i_cfg     (r_cfg),
        .o_new_pos (new_pos),
        .o_changed (changed)
    );

`ifndef SYNTH
    a_out_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result word appeared without a sample");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pos.valid && !o_pos.ready) |=> (o_pos.valid && $stable(o_pos.position)))
        else $error("waiting result word dropped or changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.ready)
        else $error("configuration channel not ready");
`endif

endmodule

FILE: tb/quadrature_encoder_accel_unit_tb.sv
// Self-checking testbench for quadrature_encoder_accel_unit: drives pin samples and
// register writes, predicts every position word and compares it on the output channel.
// Depends on qea_pkg and the qea_pins_if, qea_cfg_if and qea_pos_if interfaces.
module quadrature_encoder_accel_unit_tb
    import qea_pkg::*;
;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 4;

    // Half-step decoder: next state and detent direction per state and {pin_b, pin_a}
    localparam logic [2:0] NEXT_ST [6][4] = '{
        '{3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd3, 3'd0, 3'd1, 3'd0},
        '{3'd3, 3'd2, 3'd0, 3'd0},
        '{3'd3, 3'd5, 3'd4, 3'd0},
        '{3'd3, 3'd3, 3'd4, 3'd0},
        '{3'd3, 3'd5, 3'd3, 3'd0}
    };
    localparam t_dir DETENT_DIR [6][4] = '{
        '{DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE},
        '{DIR_CCW,  DIR_NONE, DIR_NONE, DIR_NONE},
        '{DIR_CW,   DIR_NONE, DIR_NONE, DIR_NONE},
        '{DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE},
        '{DIR_NONE, DIR_NONE, DIR_NONE, DIR_CW},
        '{DIR_NONE, DIR_NONE, DIR_NONE, DIR_CCW}
    };
    // Velocity gain per spin index
    localparam int SPIN_GAIN [5] = '{0, 16, 60, 180, 400};

    logic i_clk;
    logic i_rst_n;
    logic take_ready = 1'b0;

    qea_pins_if pins_if ();
    qea_cfg_if  cfg_if ();
    qea_pos_if  pos_if ();

    assign pos_if.ready = take_ready;

    quadrature_encoder_accel_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pins  (pins_if),
        .i_cfg   (cfg_if),
        .o_pos   (pos_if)
    );

    // Mirror of the block's registers and state
    logic       accel_on  = 1'b1;
    int         lo_limit  = 0;
    int         hi_limit  = 16383;
    int         vel_limit = 1500;
    logic [2:0] enc_state = 3'd0;
    t_dir       spin_dir  = DIR_NONE;
    int         spin_idx  = 0;
    int         enc_vel   = 0;
    int         enc_pos   = 0;

    logic signed [PosW-1:0] pending_positions [$];

    int gap_pct        = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int samples_sent   = 0;
    int cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        take_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : check_positions
        logic signed [PosW-1:0] want;
        if (i_rst_n && pos_if.valid && pos_if.ready) begin
            if (pending_positions.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected position word, expected none, actual %0d",
                         $time, pos_if.position);
            end else begin
                want = pending_positions.pop_front();
                if (pos_if.position !== want) begin
                    mismatch_count++;
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want, pos_if.position);
                end
            end
        end
    end

    // Advance the mirrored decoder and motion state by one accepted sample
    function automatic void track_sample(input logic [1:0] col);
        int   st;
        t_dir d;
        int   sgn;
        int   step;
        int   npos;
        int   prev;
        st = (enc_state > 3'd5) ? 0 : int'(enc_state);
        d = DETENT_DIR[st][col];
        enc_state = NEXT_ST[st][col];
        prev = enc_pos;
        sgn = (d == DIR_CW) ? 1 : ((d == DIR_CCW) ? -1 : 0);
        if (!accel_on) begin
            if (sgn == 0) return;
            enc_vel = 1500 * sgn;
        end else begin
            if (sgn == 0) begin
                // decay toward zero, hold at zero
                if (enc_vel > 0) enc_vel = enc_vel - 1;
                else if (enc_vel < 0) enc_vel = enc_vel + 1;
                return;
            end
            if (spin_dir == d) begin
                spin_idx = (spin_idx == 4) ? 0 : spin_idx + 1;
            end else begin
                spin_idx = 0;
                enc_vel = 0;
            end
            spin_dir = d;
            enc_vel = enc_vel + SPIN_GAIN[spin_idx] * sgn;
            if (enc_vel > 32767) enc_vel = 32767;
            else if (enc_vel < -32768) enc_vel = -32768;
        end
        step = enc_vel;
        if (step < -vel_limit) step = -vel_limit;
        else if (step > vel_limit) step = vel_limit;
        npos = enc_pos + step;
        if (npos < lo_limit) npos = lo_limit;
        else if (npos > hi_limit) npos = hi_limit;
        enc_pos = npos;
        if (enc_pos != prev) pending_positions.push_back(enc_pos[PosW-1:0]);
    endfunction

    // col is {pin_b, pin_a}; valid stays high after the word so the next one can follow
    task automatic send_sample(input logic [1:0] col);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            pins_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        pins_if.valid <= 1'b1;
        pins_if.pin_a <= col[0];
        pins_if.pin_b <= col[1];
        do @(posedge i_clk); while (!pins_if.ready);
        samples_sent++;
        track_sample(col);
    endtask

    // Sample that moves the decoder back to a rest state without a detent
    task automatic rest_sample();
        send_sample((enc_state <= 3'd2) ? 2'b11 : 2'b00);
    endtask

    task automatic turn_detent(input t_dir d);
        logic [1:0] first;
        logic [1:0] second;
        if (enc_state != 3'd0 && enc_state != 3'd3) rest_sample();
        if (enc_state == 3'd0) begin
            first  = (d == DIR_CW) ? 2'b01 : 2'b10;
            second = 2'b00;
        end else begin
            first  = (d == DIR_CW) ? 2'b10 : 2'b01;
            second = 2'b11;
        end
        send_sample(first);
        send_sample(second);
    endtask

    // Drop valid, wait for every expected word, then let the pipeline empty
    task automatic settle_block();
        pins_if.valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDatW-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_ACCEL_EN: accel_on  = val[0];
            CFG_MIN_POS:  lo_limit  = $signed(val);
            CFG_MAX_POS:  hi_limit  = $signed(val);
            CFG_MAX_VEL:  vel_limit = val[MaxVelW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] vlim);
        settle_block();
        write_reg(CFG_ACCEL_EN, {15'd0, en});
        write_reg(CFG_MIN_POS, lo);
        write_reg(CFG_MAX_POS, hi);
        write_reg(CFG_MAX_VEL, vlim);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_accel_ramp();
        set_config(1'b1, 16'd0, 16'd16383, 16'd1500);
        turn_detent(DIR_CCW);
        repeat (6) turn_detent(DIR_CW);
        turn_detent(DIR_CCW);
    endtask

    task automatic test_fixed_mode();
        set_config(1'b0, 16'h8000, 16'h7FFF, 16'd1000);
        turn_detent(DIR_CW);
        turn_detent(DIR_CW);
        turn_detent(DIR_CCW);
        rest_sample();
        rest_sample();
        set_config(1'b0, 16'h8000, 16'h7FFF, 16'h7FFF);
        turn_detent(DIR_CW);
    endtask

    task automatic test_idle_decay();
        set_config(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF);
        turn_detent(DIR_CCW);
        turn_detent(DIR_CW);
        turn_detent(DIR_CW);
        // velocity reaches zero and must stay there
        repeat (20) rest_sample();
        turn_detent(DIR_CW);
    endtask

    task automatic test_position_limits();
        // inverted window
        set_config(1'b0, 16'd100, -16'sd100, 16'h7FFF);
        turn_detent(DIR_CW);
        turn_detent(DIR_CCW);
        turn_detent(DIR_CW);
        // zero step, then a position left outside a narrowed window
        set_config(1'b0, 16'h8000, 16'h7FFF, 16'd0);
        turn_detent(DIR_CW);
        set_config(1'b0, -16'sd20, 16'd10, 16'd0);
        turn_detent(DIR_CW);
        set_config(1'b0, 16'h8000, 16'h8000, 16'h7FFF);
        turn_detent(DIR_CW);
        set_config(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        turn_detent(DIR_CCW);
    endtask

    // Long same-direction runs wrap the acceleration index several times
    task automatic test_direction_runs();
        set_config(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF);
        repeat (25) turn_detent(DIR_CW);
        repeat (25) turn_detent(DIR_CCW);
    endtask

    task automatic randomize_config();
        logic        en;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] vlim;
        en = ($urandom_range(3) != 0);
        case ($urandom_range(4))
            0: begin lo = 16'h8000; hi = 16'h7FFF; end
            1: begin lo = 16'($urandom); hi = 16'($urandom); end
            2: begin lo = -16'sd2000; hi = 16'd2000; end
            3: begin lo = 16'd300; hi = -16'sd300; end
            default: begin lo = 16'd0; hi = 16'd16383; end
        endcase
        case ($urandom_range(3))
            0: vlim = {1'($urandom_range(1)), 15'd0};
            1: vlim = {1'($urandom_range(1)), 15'h7FFF};
            2: vlim = 16'($urandom);
            default: vlim = 16'd1500;
        endcase
        set_config(en, lo, hi, vlim);
    endtask

    // Mostly whole detents with long same-direction runs, some idle and some noise
    task automatic random_samples(input int count);
        int   first_sent;
        int   pick;
        t_dir heading;
        first_sent = samples_sent;
        heading = DIR_CW;
        while (samples_sent - first_sent < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(99) < 15) heading = (heading == DIR_CW) ? DIR_CCW : DIR_CW;
                turn_detent(heading);
            end else if (pick < 85) begin
                rest_sample();
            end else begin
                send_sample(2'($urandom_range(3)));
            end
        end
    endtask

    task automatic random_phase(input int send_idle, input int recv_stall);
        gap_pct   = send_idle;
        stall_pct = recv_stall;
        repeat (2) begin
            randomize_config();
            random_samples(30);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        pins_if.valid <= 1'b0;
        pins_if.pin_a <= 1'b0;
        pins_if.pin_b <= 1'b0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_ACCEL_EN;
        cfg_if.data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_accel_ramp();
        test_fixed_mode();
        test_idle_decay();
        test_position_limits();
        test_direction_runs();

        random_phase(0, 0);
        random_phase(60, 0);
        random_phase(0, 60);
        random_phase(19, 19);

        settle_block();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: quadrature_encoder_accel_unit.f
src/qea_pkg.sv
src/qea_pins_if.sv
src/qea_pos_if.sv
src/qea_cfg_if.sv
src/qea_decode.sv
src/qea_motion.sv
src/quadrature_encoder_accel_unit.sv
tb/quadrature_encoder_accel_unit_tb.sv
